// ===== sv/yuv411_to_argb_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef YUV411_TO_ARGB_CONVERTER_MACROS_SVH
`define YUV411_TO_ARGB_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must never hold.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
// Consequent holds in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(lbl, expr, msg)
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/y2a_pkg.sv =====
// Shared types, constants and helpers of the YUV 4:1:1 to ARGB converter.
`default_nettype none
package y2a_pkg;
	localparam int WORD_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = 24;
	localparam int TOTAL_W   = 2 * CFG_W;
	localparam int PROD_W    = 21;
	localparam int FRAC_W    = 10;
	localparam int OFS_W     = PROD_W - FRAC_W;
	localparam int SUM_W     = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [TOTAL_W-1:0] FRAME_LIMIT    = 26'h100_0000;

	// Conversion coefficients, scaled by 1024
	localparam logic signed [11:0] COEF_RV = 12'sd1436;
	localparam logic signed [11:0] COEF_GU = 12'sd352;
	localparam logic signed [11:0] COEF_GV = 12'sd731;
	localparam logic signed [11:0] COEF_BU = 12'sd1814;
	localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;
	localparam logic [BYTE_W-1:0]  CHAN_ALPHA  = 8'hFF;
	localparam logic signed [SUM_W-1:0] CHAN_MAX = 12'sd255;

	// Word position inside a three-word group
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	// One pixel handed from the front to the back
	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] v;
		logic [BYTE_W-1:0] u;
		logic [BYTE_W-1:0] y;
	} pix_t;

	// Saturate a signed channel sum to 0..255
	function automatic logic [BYTE_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
		logic [BYTE_W-1:0] r;
		if (x[SUM_W-1])
			r = '0;
		else if (x > CHAN_MAX)
			r = CHAN_ALPHA;
		else
			r = x[BYTE_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/y2a_fifo.sv =====
// Short pixel queue between the word sequencer and the conversion pipeline.
`default_nettype none
`include "yuv411_to_argb_converter_macros.svh"
module y2a_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire y2a_pkg::pix_t    push_data,
	output logic                  full,
	input  wire                   pop,
	output y2a_pkg::pix_t         pop_data,
	output logic                  empty
);
	import y2a_pkg::*;

	pix_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QUEUE_CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QUEUE_CW'(1);
		end
	end

	`ASSERT_NEVER(a_fifo_level, count_q > QUEUE_CW'(QUEUE_DEPTH), "queue level beyond depth")
endmodule
`default_nettype wire

// ===== sv/y2a_front.sv =====
// Front end: takes stream words, tracks the group phase and chroma, issues pixels.
`default_nettype none
`include "yuv411_to_argb_converter_macros.svh"
module y2a_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [y2a_pkg::WORD_W-1:0] s_tdata,
	output logic                       push,
	output y2a_pkg::pix_t              push_data,
	input  wire                        full
);
	import y2a_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [BYTE_W-1:0]      held_u_q, held_u_d;
	logic [BYTE_W-1:0]      held_v_q, held_v_d;
	logic [BYTE_W-1:0]      held_luma_q, held_luma_d;
	logic                   busy_q;
	logic [1:0]             idx_q;
	logic [1:0]             last_idx_q, last_idx_d;
	logic [3:0][BYTE_W-1:0] luma_q, luma_d;
	logic [BYTE_W-1:0]      word_u_q, word_u_d;
	logic [BYTE_W-1:0]      word_v_q, word_v_d;
	logic [3:0][BYTE_W-1:0] b;
	logic                   accept;
	logic                   emit;
	logic                   done;

	assign b = s_tdata;

	// Pixel issue, one per cycle while the queue has room
	assign emit     = busy_q && !full;
	assign done     = emit && (idx_q == last_idx_q);
	assign s_tready = !busy_q || done;
	assign accept   = s_tvalid && s_tready;
	assign push     = emit;
	assign push_data = '{last: (idx_q == last_idx_q), v: word_v_q, u: word_u_q,
		y: luma_q[idx_q]};

	// Word unpacking by group phase
	always_comb begin
		phase_d     = phase_q;
		held_u_d    = held_u_q;
		held_v_d    = held_v_q;
		held_luma_d = held_luma_q;
		luma_d      = '0;
		word_u_d    = held_u_q;
		word_v_d    = held_v_q;
		last_idx_d  = 2'd1;
		case (phase_q)
			PH_SECOND: begin
				luma_d[0]   = b[0];
				luma_d[1]   = b[1];
				held_u_d    = b[2];
				held_luma_d = b[3];
				phase_d     = PH_THIRD;
			end
			PH_THIRD: begin
				held_v_d   = b[1];
				word_v_d   = b[1];
				luma_d[0]  = held_luma_q;
				luma_d[1]  = b[0];
				luma_d[2]  = b[2];
				luma_d[3]  = b[3];
				last_idx_d = 2'd3;
				phase_d    = PH_FIRST;
			end
			default: begin
				held_u_d  = b[0];
				held_v_d  = b[3];
				word_u_d  = b[0];
				word_v_d  = b[3];
				luma_d[0] = b[1];
				luma_d[1] = b[2];
				phase_d   = PH_SECOND;
			end
		endcase
	end

	// Per-word pixel set
	always_ff @(posedge clk) begin
		if (accept) begin
			luma_q     <= luma_d;
			word_u_q   <= word_u_d;
			word_v_q   <= word_v_d;
			last_idx_q <= last_idx_d;
		end
	end

	// Group state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			held_u_q    <= '0;
			held_v_q    <= '0;
			held_luma_q <= '0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			held_u_q    <= held_u_d;
			held_v_q    <= held_v_d;
			held_luma_q <= held_luma_d;
			busy_q      <= 1'b1;
			idx_q       <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	`ASSERT_NEVER(a_idx_range, busy_q && (idx_q > last_idx_q), "pixel index past word end")
	`ASSERT_IMP(a_ready_idle, !busy_q, s_tready, "front idle but not ready")
endmodule
`default_nettype wire

// ===== sv/y2a_back.sv =====
// Back end: color conversion pipeline, frame counter and output register.
`default_nettype none
`include "yuv411_to_argb_converter_macros.svh"
module y2a_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_avail,
	input  wire y2a_pkg::pix_t         in_data,
	output logic                       pop,
	input  wire  [y2a_pkg::CFG_W-1:0]  frame_width,
	input  wire  [y2a_pkg::CFG_W-1:0]  frame_height,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [31:0]                m_tdata,  // alpha, red, green, blue
	output logic                       m_tuser,  // word_last
	output logic                       m_tlast   // frame_end
);
	import y2a_pkg::*;

	logic                      adv;
	logic signed [8:0]         uc;
	logic signed [8:0]         vc;
	logic                      v_s1;
	logic [BYTE_W-1:0]         y_s1;
	logic                      last_s1;
	logic signed [PROD_W-1:0]  prod_r_s1;
	logic signed [PROD_W-1:0]  prod_g_s1;
	logic signed [PROD_W-1:0]  prod_b_s1;
	logic signed [OFS_W-1:0]   ofs_r;
	logic signed [OFS_W-1:0]   ofs_g;
	logic signed [OFS_W-1:0]   ofs_b;
	logic signed [SUM_W-1:0]   ysx;
	logic signed [SUM_W-1:0]   sum_r;
	logic signed [SUM_W-1:0]   sum_g;
	logic signed [SUM_W-1:0]   sum_b;
	logic [TOTAL_W-1:0]        total_q;
	logic                      frame_ok;
	logic [CNT_W:0]            next_cnt;
	logic                      fend_d;
	logic [CNT_W-1:0]          pixel_count_q;
	logic                      out_valid_q;
	logic [BYTE_W-1:0]         red_q, green_q, blue_q;
	logic                      word_last_q;
	logic                      frame_end_q;

	// Whole pipeline moves when the output register is free or drained
	assign adv = !out_valid_q || m_tready;
	assign pop = adv && in_avail;

	// Stage 1: centered chroma times coefficients
	assign uc = $signed({1'b0, in_data.u}) - CHROMA_BIAS;
	assign vc = $signed({1'b0, in_data.v}) - CHROMA_BIAS;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1      <= in_data.y;
			last_s1   <= in_data.last;
			prod_r_s1 <= PROD_W'(vc) * PROD_W'(COEF_RV);
			prod_g_s1 <= PROD_W'(uc) * PROD_W'(COEF_GU) + PROD_W'(vc) * PROD_W'(COEF_GV);
			prod_b_s1 <= PROD_W'(uc) * PROD_W'(COEF_BU);
		end
	end

	// Stage 2: floor shift, add luma, clamp
	assign ofs_r = $signed(prod_r_s1[PROD_W-1:FRAC_W]);
	assign ofs_g = $signed(prod_g_s1[PROD_W-1:FRAC_W]);
	assign ofs_b = $signed(prod_b_s1[PROD_W-1:FRAC_W]);
	assign ysx   = $signed({{(SUM_W-BYTE_W){1'b0}}, y_s1});
	assign sum_r = ysx + SUM_W'(ofs_r);
	assign sum_g = ysx - SUM_W'(ofs_g);
	assign sum_b = ysx + SUM_W'(ofs_b);

	// Frame size, registered from the configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else
			total_q <= TOTAL_W'(frame_width) * TOTAL_W'(frame_height);
	end

	// Frame end detect
	assign frame_ok = (total_q != '0) && (total_q <= FRAME_LIMIT);
	assign next_cnt = {1'b0, pixel_count_q} + (CNT_W+1)'(1);
	assign fend_d   = frame_ok && (next_cnt == total_q[CNT_W:0]);

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			red_q       <= clamp8(sum_r);
			green_q     <= clamp8(sum_g);
			blue_q      <= clamp8(sum_b);
			word_last_q <= last_s1;
			frame_end_q <= fend_d;
		end
	end

	// Valid bits and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			out_valid_q   <= 1'b0;
			pixel_count_q <= '0;
		end else if (adv) begin
			v_s1        <= in_avail;
			out_valid_q <= v_s1;
			if (v_s1)
				pixel_count_q <= fend_d ? '0 : next_cnt[CNT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {blue_q, green_q, red_q, CHAN_ALPHA};
	assign m_tuser  = word_last_q;
	assign m_tlast  = frame_end_q;

	`ASSERT_NEXT(a_count_restart, adv && v_s1 && fend_d, pixel_count_q == '0,
		"pixel count not restarted after frame end")
endmodule
`default_nettype wire

// ===== sv/yuv411_to_argb_converter.sv =====
// YUV 4:1:1 stream words in, one clamped ARGB pixel out per transaction.
// Each input word (bytes U Y Y V Y Y across a three-word group, low byte first)
// yields 2, 2 and 4 pixels; the output delivers one pixel per cycle while
// m_tready is high and pixels are queued. The front sequencer holds a word
// until it issues its last pixel, one pixel per cycle while the queue has
// room, into a four-entry queue feeding a two-stage conversion pipeline
// (multiply, then shift/add/clamp into the output register). A word's first
// pixel passes the word registers, the queue, the stage-1 and the output
// registers before it is offered. m_tuser marks the last pixel of each word,
// m_tlast the last pixel of the frame (frame_width * frame_height pixels; no
// end mark if that product is zero or above 2^24). Configuration writes are
// taken at any time, one per cycle, and should be made while the block is
// idle; they pass the configuration and frame-size registers to take effect.
`default_nettype none
module yuv411_to_argb_converter (
	input  wire                           clk,
	input  wire                           arst_n,
	// Input stream
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [y2a_pkg::WORD_W-1:0]    s_tdata,   // word_data
	// Output stream
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [31:0]                   m_tdata,   // alpha, red, green, blue
	output logic                          m_tuser,   // word_last
	output logic                          m_tlast,   // frame_end
	// Configuration writes
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [y2a_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [y2a_pkg::CFG_W-1:0]     cfg_data
);
	import y2a_pkg::*;

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             push;
	pix_t             push_data;
	logic             full;
	logic             pop;
	pix_t             pop_data;
	logic             empty;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	y2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	y2a_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	y2a_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_avail     (!empty),
		.in_data      (pop_data),
		.pop          (pop),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);
endmodule
`default_nettype wire

// ===== tb/tb_yuv411_to_argb_converter.sv =====
// Self-checking testbench for the YUV 4:1:1 to ARGB stream converter.
`default_nettype none
module tb_yuv411_to_argb_converter;
	import y2a_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 100;
	localparam int MAX_IDLE      = 4;
	localparam int TIMEOUT       = 2_000_000;

	// Register indexes past the end of the register list; writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	// One expected output pixel
	typedef struct packed {
		logic [BYTE_W-1:0] alpha;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              word_last;
		logic              frame_end;
	} pixel_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata;   // word_data
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;   // alpha, red, green, blue
	logic                 m_tuser;   // word_last
	logic                 m_tlast;   // frame_end
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Converter state mirrored by the predictor
	phase_t            grp_phase;
	logic [BYTE_W-1:0] cur_u;
	logic [BYTE_W-1:0] cur_v;
	logic [BYTE_W-1:0] carry_luma;
	logic [CNT_W-1:0]  pix_count;
	logic [CFG_W-1:0]  cur_width;
	logic [CFG_W-1:0]  cur_height;

	pixel_t pending_pixels[$];
	bit     idle_on;
	bit     hold_req;
	int     error_count;
	int     words_sent;
	int     pixels_checked;
	int     frame_ends_seen;

	yuv411_to_argb_converter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Watchdog
	initial begin
		#TIMEOUT;
		$display("FAILURE");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic [BYTE_W-1:0] sat8(input int x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'hFF;
		return x[BYTE_W-1:0];
	endfunction

	// Convert one pixel, advance the frame counter and queue the result
	task automatic push_pixel(input logic [BYTE_W-1:0] y, input logic word_end);
		int          uc;
		int          vc;
		int          yy;
		logic [31:0] total;
		logic [31:0] nxt;
		pixel_t      p;
		uc = int'(cur_u) - CHROMA_BIAS;
		vc = int'(cur_v) - CHROMA_BIAS;
		yy = int'(y);
		total = 32'(cur_width) * 32'(cur_height);
		nxt = 32'(pix_count) + 32'd1;
		p.alpha = CHAN_ALPHA;
		p.red = sat8(yy + ((vc * COEF_RV) >>> FRAC_W));
		p.green = sat8(yy - ((uc * COEF_GU + vc * COEF_GV) >>> FRAC_W));
		p.blue = sat8(yy + ((uc * COEF_BU) >>> FRAC_W));
		p.word_last = word_end;
		p.frame_end = (total != 0) && (total <= 32'(FRAME_LIMIT)) && (nxt == total);
		pix_count = p.frame_end ? '0 : nxt[CNT_W-1:0];
		pending_pixels.push_back(p);
	endtask

	// Expected pixels of one accepted word
	task automatic predict_word(input logic [WORD_W-1:0] w);
		case (grp_phase)
			PH_SECOND: begin
				push_pixel(w[7:0], 1'b0);
				push_pixel(w[15:8], 1'b1);
				cur_u = w[23:16];
				carry_luma = w[31:24];
				grp_phase = PH_THIRD;
			end
			PH_THIRD: begin
				cur_v = w[15:8];
				push_pixel(carry_luma, 1'b0);
				push_pixel(w[7:0], 1'b0);
				push_pixel(w[23:16], 1'b0);
				push_pixel(w[31:24], 1'b1);
				grp_phase = PH_FIRST;
			end
			default: begin
				cur_u = w[7:0];
				cur_v = w[31:24];
				push_pixel(w[15:8], 1'b0);
				push_pixel(w[23:16], 1'b1);
				grp_phase = PH_SECOND;
			end
		endcase
	endtask

	// Offer one word; valid stays high into the next word unless a gap is drawn
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		predict_word(w);
		words_sent++;
	endtask

	// Three words carrying one chroma pair and one luma value for all pixels
	task automatic send_group(input logic [7:0] u, input logic [7:0] v, input logic [7:0] y);
		send_word({v, y, y, u});
		send_word({y, u, y, y});
		send_word({y, y, v, y});
	endtask

	// Bytes biased toward the clamp corners and the chroma midpoint
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'(8'h7E + $urandom_range(0, 4));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		if ($urandom_range(0, 2) == 0)
			return WORD_W'($urandom);
		return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
	endfunction

	// Smallest height that puts the frame end ahead of the running count, plus extra rows
	function automatic logic [CFG_W-1:0] fit_height(input logic [CFG_W-1:0] width,
	                                                 input int extra);
		return CFG_W'(int'(pix_count) / int'(width) + 1 + extra);
	endfunction

	// Drain all outstanding pixels, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program the frame size, plus one write to an unused index
	task automatic set_frame(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [CFG_W-1:0]     val [3];
		idx[0] = REG_FRAME_WIDTH;
		val[0] = width;
		idx[1] = REG_FRAME_HEIGHT;
		val[1] = height;
		idx[2] = $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
		val[2] = CFG_W'($urandom);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_FRAME_WIDTH: cur_width = val[i];
				REG_FRAME_HEIGHT: cur_height = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stall after each pixel when idle_on, long hold on request
	initial begin : rx_ready
		int stall;
		wait (arst_n);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			stall = 0;
			if (m_tvalid && m_tready && idle_on)
				stall = $urandom_range(0, MAX_IDLE);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				for (int n = 0; n < stall; n++) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted pixel against the oldest expectation
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel %08h", m_tdata));
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (want.frame_end)
					frame_ends_seen++;
				if (m_tdata[7:0] !== want.alpha)
					flag_error($sformatf("alpha %02h, expected %02h", m_tdata[7:0], want.alpha));
				if (m_tdata[15:8] !== want.red)
					flag_error($sformatf("red %02h, expected %02h", m_tdata[15:8], want.red));
				if (m_tdata[23:16] !== want.green)
					flag_error($sformatf("green %02h, expected %02h", m_tdata[23:16],
						want.green));
				if (m_tdata[31:24] !== want.blue)
					flag_error($sformatf("blue %02h, expected %02h", m_tdata[31:24], want.blue));
				if (m_tuser !== want.word_last)
					flag_error($sformatf("word_last %b, expected %b", m_tuser, want.word_last));
				if (m_tlast !== want.frame_end)
					flag_error($sformatf("frame_end %b, expected %b", m_tlast, want.frame_end));
			end
		end
	end

	// Reset values: clamp corners, neutral chroma and floor rounding, no frame end
	task automatic test_reset_defaults();
		idle_on = 1'b1;
		send_group(8'h00, 8'h00, 8'h00);
		send_group(8'hFF, 8'hFF, 8'hFF);
		send_group(8'h80, 8'h80, 8'h80);
		send_group(8'h00, 8'hFF, 8'hFF);
		send_group(8'hFF, 8'h00, 8'h00);
		send_group(8'h7F, 8'h7F, 8'h01);
		send_group(8'h81, 8'h81, 8'hFE);
		send_word(32'hAAAA_AAAA);
		send_word(32'h5555_5555);
		send_word(32'h0F0F_F0F0);
		wait_idle();
	endtask

	// Eight-wide frames of whole groups, so frame ends fall on group ends
	task automatic test_small_frame();
		set_frame(13'd8, fit_height(13'd8, 0));
		for (int i = 0; i < 45; i++)
			send_word(pick_word());
		wait_idle();
	endtask

	// Frames that are no multiple of eight, so groups straddle frame ends
	task automatic test_odd_frames();
		set_frame(13'd9, fit_height(13'd9, 0));
		for (int i = 0; i < 24; i++)
			send_word(pick_word());
		wait_idle();
		set_frame(13'd13, fit_height(13'd13, 2));
		for (int i = 0; i < 21; i++)
			send_word(pick_word());
		wait_idle();
	endtask

	// Largest frame, oversized and zero products: the count just runs on
	task automatic test_extreme_sizes();
		set_frame(13'd4096, 13'd4096);
		for (int i = 0; i < 12; i++)
			send_word(pick_word());
		wait_idle();
		set_frame(13'h1FFF, 13'h1FFF);
		for (int i = 0; i < 12; i++)
			send_word(pick_word());
		wait_idle();
		set_frame(13'd8, 13'd0);
		for (int i = 0; i < 6; i++)
			send_word(pick_word());
		wait_idle();
		set_frame(13'd0, 13'd4096);
		for (int i = 0; i < 6; i++)
			send_word(pick_word());
		wait_idle();
	endtask

	// Receiver holds off while words keep coming, filling the block
	task automatic test_backpressure();
		set_frame(13'd12, fit_height(13'd12, 1));
		idle_on = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_word(pick_word());
		wait_idle();
		idle_on = 1'b1;
	endtask

	// Random frame sizes, with and without idle cycles
	task automatic test_random_mix();
		logic [CFG_W-1:0] width;
		for (int round = 0; round < 6; round++) begin
			width = CFG_W'($urandom_range(8, 40));
			set_frame(width, fit_height(width, $urandom_range(0, 2)));
			idle_on = (round % 3) != 0;
			for (int i = 0; i < 15; i++)
				send_word(pick_word());
			wait_idle();
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		grp_phase = PH_FIRST;
		cur_u = '0;
		cur_v = '0;
		carry_luma = '0;
		pix_count = '0;
		cur_width = FRAME_WIDTH_RST;
		cur_height = FRAME_HEIGHT_RST;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_small_frame();
		test_odd_frames();
		test_extreme_sizes();
		test_backpressure();
		test_random_mix();

		if (pending_pixels.size() != 0)
			flag_error($sformatf("%0d pixels never arrived", pending_pixels.size()));
		$display("Run: %0d words in, %0d pixels compared, %0d frame ends among them",
			words_sent, pixels_checked, frame_ends_seen);
		$display("Sizes: reset, 8/9/13-wide frames, 4096x4096, oversized, zero, random");
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
